[sv/iopd_pkg.sv]
// ----------------------------------------------------------------------------
// iopd_pkg
// Shared types and constants for the I/O port decoder with serial receiver.
// ----------------------------------------------------------------------------
package iopd_pkg;

	localparam logic [7:0]  CTRL_ADDR_MAX = 8'h3F;
	localparam logic [7:0]  AB_ADDR_MIN   = 8'hC0;
	localparam logic [7:0]  AB_ADDR_MAX   = 8'hFE;
	localparam logic [7:0]  BM_ADDR_MIN   = 8'hC1;
	localparam logic [7:0]  CTRL_RESET    = 8'hFF;
	localparam logic [15:0] TPB_RESET     = 16'd100;

	// frame length in bit times; the last window index of the receiver
	localparam int unsigned FRAME_BITS = 10;
	localparam int unsigned TICK_W     = 20;
	localparam int unsigned WIN_W      = 4;

	// data bits collected plus the start mark
	localparam logic [WIN_W-1:0] BITS_FULL = 4'd9;

	typedef struct packed {
		logic       ctrl_wr;
		logic       rd_hit;
		logic [7:0] rd_data;
	} iopd_dec_t;

	typedef struct packed {
		logic       done;
		logic [7:0] data;
	} iopd_rx_t;

endpackage

[sv/iopd_decode.sv]
// ----------------------------------------------------------------------------
// iopd_decode
// Address decode for one bus tick and the control register it loads.
// ----------------------------------------------------------------------------
module iopd_decode #(
	parameter int unsigned LINE_BIT = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                chip_disabled,
	input  logic                ioreq_n,
	input  logic                rd_n,
	input  logic                wr_n,
	input  logic [7:0]          address_low,
	input  logic [7:0]          write_data,
	input  logic [7:0]          port_ab_pins,
	input  logic [7:0]          port_bm_pins,
	output iopd_pkg::iopd_dec_t dec,
	output logic                line
);
	import iopd_pkg::*;

	logic [7:0] control_q;
	logic [7:0] control_next;
	logic       sel;

	assign sel = !chip_disabled && !ioreq_n;

	always_comb begin
		dec = '0;
		priority if (sel && !wr_n && address_low <= CTRL_ADDR_MAX && address_low[0]) begin
			dec.ctrl_wr = 1'b1;
		end else if (sel && !rd_n && address_low >= AB_ADDR_MIN && !address_low[0]
				&& address_low <= AB_ADDR_MAX) begin
			dec.rd_hit  = 1'b1;
			dec.rd_data = port_ab_pins;
		end else if (sel && !rd_n && address_low >= BM_ADDR_MIN && address_low[0]) begin
			dec.rd_hit  = 1'b1;
			dec.rd_data = port_bm_pins;
		end else begin
			dec = '0;
		end
	end

	// receiver samples the line after a write on the same tick
	assign control_next = dec.ctrl_wr ? write_data : control_q;
	assign line         = control_next[LINE_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= CTRL_RESET;
		end else if (advance) begin
			control_q <= control_next;
		end
	end

endmodule

[sv/iopd_rx.sv]
// ----------------------------------------------------------------------------
// iopd_rx
// 8N1 receiver on the bit-banged line, advanced once per bus tick.
// ----------------------------------------------------------------------------
module iopd_rx (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               line,
	input  logic [15:0]        ticks_per_bit,
	output iopd_pkg::iopd_rx_t rx
);
	import iopd_pkg::*;

	logic              active_q;
	logic [TICK_W-1:0] ticks_q;
	logic [WIN_W-1:0]  bits_q;
	logic [7:0]        shift_q;

	logic [TICK_W-1:0] ticks_inc;
	logic [TICK_W-1:0] bit_t;
	logic [WIN_W-1:0]  win;

	assign ticks_inc = ticks_q + TICK_W'(1);
	assign bit_t     = TICK_W'(ticks_per_bit);

	// window index: largest k up to FRAME_BITS with ticks > k*T; bounds rise with k for nonzero T
	always_comb begin
		win = '0;
		for (int k = 1; k <= FRAME_BITS; k++) begin
			if (ticks_inc > TICK_W'(bit_t * TICK_W'(k)))
				win = WIN_W'(k);
		end
	end

	assign rx.done = active_q && (win == WIN_W'(FRAME_BITS)) && (bits_q == BITS_FULL);
	assign rx.data = rx.done ? shift_q : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ticks_q  <= '0;
			bits_q   <= '0;
			shift_q  <= '0;
		end else if (advance) begin
			if (!active_q) begin
				if (!line) begin
					active_q <= 1'b1;
					ticks_q  <= '0;
					bits_q   <= '0;
					shift_q  <= '0;
				end
			end else begin
				ticks_q <= ticks_inc;
				priority if (win == WIN_W'(FRAME_BITS)) begin
					active_q <= 1'b0;
				end else if (win >= WIN_W'(2)) begin
					if (bits_q == win - WIN_W'(1)) begin
						shift_q <= {line, shift_q[7:1]};
						bits_q  <= bits_q + WIN_W'(1);
					end
				end else if (win == WIN_W'(1)) begin
					bits_q <= WIN_W'(1);
				end else begin
					bits_q <= bits_q;
				end
			end
		end
	end

endmodule

[sv/io_port_decode_with_uart_rx_unit.sv]
// ----------------------------------------------------------------------------
// io_port_decode_with_uart_rx_unit
// Bus tick decoder for control/port registers plus a serial byte receiver.
// ----------------------------------------------------------------------------
// Each input beat is one bus tick and yields exactly one result beat. The unit
// takes a beat every cycle while the output is not stalled: a tick sits in the
// input register, where it is decoded and advances the receiver, and its result
// then lands in the output register. A stalled output holds the input register
// and then in_ready. The user writes ticks_per_bit through the cfg channel only
// while no tick is in flight; the block itself does not enforce this.
module io_port_decode_with_uart_rx_unit #(
	parameter int unsigned LINE_BIT = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        chip_disabled,
	input  logic        ioreq_n,
	input  logic        rd_n,
	input  logic        wr_n,
	input  logic [7:0]  address_low,
	input  logic [7:0]  write_data,
	input  logic [7:0]  port_ab_pins,
	input  logic [7:0]  port_bm_pins,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic [7:0]  rx_byte,
	output logic        rx_valid
);
	import iopd_pkg::*;

	logic [15:0] tpb_q;

	logic       valid_s1;
	logic       chip_disabled_s1;
	logic       ioreq_n_s1;
	logic       rd_n_s1;
	logic       wr_n_s1;
	logic [7:0] address_low_s1;
	logic [7:0] write_data_s1;
	logic [7:0] port_ab_pins_s1;
	logic [7:0] port_bm_pins_s1;

	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       read_valid_q;
	logic [7:0] rx_byte_q;
	logic       rx_valid_q;

	logic       advance;
	iopd_dec_t  dec;
	iopd_rx_t   rx;
	logic       line;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q <= TPB_RESET;
		end else if (cfg_valid) begin
			tpb_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			chip_disabled_s1 <= chip_disabled;
			ioreq_n_s1       <= ioreq_n;
			rd_n_s1          <= rd_n;
			wr_n_s1          <= wr_n;
			address_low_s1   <= address_low;
			write_data_s1    <= write_data;
			port_ab_pins_s1  <= port_ab_pins;
			port_bm_pins_s1  <= port_bm_pins;
		end
	end

	iopd_decode #(
		.LINE_BIT(LINE_BIT)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.chip_disabled(chip_disabled_s1),
		.ioreq_n      (ioreq_n_s1),
		.rd_n         (rd_n_s1),
		.wr_n         (wr_n_s1),
		.address_low  (address_low_s1),
		.write_data   (write_data_s1),
		.port_ab_pins (port_ab_pins_s1),
		.port_bm_pins (port_bm_pins_s1),
		.dec          (dec),
		.line         (line)
	);

	iopd_rx u_rx (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.line         (line),
		.ticks_per_bit(tpb_q),
		.rx           (rx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q  <= dec.rd_data;
			read_valid_q <= dec.rd_hit;
			rx_byte_q    <= rx.data;
			rx_valid_q   <= rx.done;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign read_valid = read_valid_q;
	assign rx_byte    = rx_byte_q;
	assign rx_valid   = rx_valid_q;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I/O port decoder with bit-banged serial receiver.
// ----------------------------------------------------------------------------
// Bus ticks are queued by the stimulus process and driven one beat at a time.
// Each accepted tick runs through a local model of the decoder and receiver.
// Result beats are checked field by field against that model, in order.
// Serial frames are built from control writes that set the line bit at each
// window. They are mixed with random bus traffic, skewed frames and noise.
// The bit time is varied between phases, including zero and the maximum.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iopd_pkg::*;

	localparam int unsigned LINE_BIT  = 7;
	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned RAND_ITEMS = 360;

	typedef struct packed {
		logic       chip_disabled;
		logic       ioreq_n;
		logic       rd_n;
		logic       wr_n;
		logic [7:0] address_low;
		logic [7:0] write_data;
		logic [7:0] port_ab_pins;
		logic [7:0] port_bm_pins;
	} bus_tick_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic [7:0] rx_byte;
		logic       rx_valid;
	} bus_result_t;

	typedef enum int {GEN_CTRL_WR, GEN_AB_RD, GEN_BM_RD, GEN_NOISE} gen_op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        chip_disabled = 1'b0;
	logic        ioreq_n = 1'b1;
	logic        rd_n = 1'b1;
	logic        wr_n = 1'b1;
	logic [7:0]  address_low = '0;
	logic [7:0]  write_data = '0;
	logic [7:0]  port_ab_pins = '0;
	logic [7:0]  port_bm_pins = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_data;
	logic        read_valid;
	logic [7:0]  rx_byte;
	logic        rx_valid;

	io_port_decode_with_uart_rx_unit #(.LINE_BIT(LINE_BIT)) dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// local copy of the block's state
	logic [15:0]       bit_time = TPB_RESET;
	logic [7:0]        ctrl_q = CTRL_RESET;
	logic [7:0]        rx_sh = '0;
	logic              rx_on = 1'b0;
	logic [TICK_W-1:0] rx_cnt = '0;
	logic [WIN_W-1:0]  rx_taken = '0;

	bus_tick_t   bus_ticks[$];
	bus_result_t pending_results[$];
	bus_tick_t   cur;

	int unsigned send_idle_pct = 0;
	int unsigned rcv_idle_pct = 0;
	int unsigned acc_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned errors = 0;
	int unsigned ticks_checked = 0;
	int unsigned port_reads = 0;
	int unsigned rx_bytes = 0;
	int unsigned stall_at = 32'hFFFF_FFFF;
	int unsigned stall_left = 0;
	bit          stall_done = 1'b0;
	bit          gen_line = 1'b1;
	int unsigned gen_cnt = 0;

	function automatic bit ctrl_write_hit(bus_tick_t t);
		return !t.chip_disabled && !t.ioreq_n && !t.wr_n &&
			t.address_low <= CTRL_ADDR_MAX && t.address_low[0];
	endfunction

	task automatic decode_and_receive(input bus_tick_t t, output bus_result_t r);
		int unsigned bt;
		int          k;
		bit          hit;
		r = '0;
		bt = bit_time;
		if (ctrl_write_hit(t)) begin
			ctrl_q = t.write_data;
		end else if (!t.chip_disabled && !t.ioreq_n && !t.rd_n) begin
			if (t.address_low >= AB_ADDR_MIN && t.address_low <= AB_ADDR_MAX &&
					!t.address_low[0]) begin
				r.read_data  = t.port_ab_pins;
				r.read_valid = 1'b1;
			end else if (t.address_low >= BM_ADDR_MIN && t.address_low[0]) begin
				r.read_data  = t.port_bm_pins;
				r.read_valid = 1'b1;
			end
		end
		// receiver sees a control write made on the same tick
		if (!rx_on) begin
			if (!ctrl_q[LINE_BIT]) begin
				rx_cnt   = '0;
				rx_taken = '0;
				rx_sh    = '0;
				rx_on    = 1'b1;
			end
		end else begin
			rx_cnt = rx_cnt + 1'b1;
			if (rx_cnt > FRAME_BITS * bt) begin
				if (rx_taken == BITS_FULL) begin
					r.rx_byte  = rx_sh;
					r.rx_valid = 1'b1;
				end
				rx_on = 1'b0;
			end else begin
				hit = 1'b0;
				for (k = FRAME_BITS - 1; k >= 2; k--) begin
					if (!hit && rx_cnt > bt * k) begin
						hit = 1'b1;
						if (rx_taken == k - 1) begin
							rx_sh    = {ctrl_q[LINE_BIT], rx_sh[7:1]};
							rx_taken = rx_taken + 1'b1;
						end
					end
				end
				if (!hit && rx_cnt > bt)
					rx_taken = WIN_W'(1);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic bus_tick_t rand_tick(bit line);
		bus_tick_t t;
		t = bus_tick_t'(36'({$urandom, $urandom}));
		t.chip_disabled = ($urandom_range(0, 7) == 0);
		t.ioreq_n = ($urandom_range(0, 7) == 0);
		case (gen_op_t'($urandom_range(0, 3)))
			GEN_CTRL_WR: begin
				t.wr_n = 1'b0;
				t.address_low = {2'b00, 5'($urandom_range(0, 31)), 1'b1};
			end
			GEN_AB_RD: begin
				t.rd_n = 1'b0;
				t.address_low = {2'b11, 5'($urandom_range(0, 31)), 1'b0};
			end
			GEN_BM_RD: begin
				t.rd_n = 1'b0;
				t.address_low = {2'b11, 5'($urandom_range(0, 31)), 1'b1};
			end
			default: ;
		endcase
		if (ctrl_write_hit(t))
			t.write_data[LINE_BIT] = line;
		return t;
	endfunction

	function automatic bus_tick_t line_tick(bit line);
		bus_tick_t t;
		t = rand_tick(line);
		t.chip_disabled = 1'b0;
		t.ioreq_n = 1'b0;
		t.wr_n = 1'b0;
		t.address_low = {2'b00, 5'($urandom_range(0, 31)), 1'b1};
		t.write_data[LINE_BIT] = line;
		return t;
	endfunction

	task automatic queue_tick(bus_tick_t t);
		if (ctrl_write_hit(t))
			gen_line = t.write_data[LINE_BIT];
		bus_ticks.push_back(t);
		gen_cnt++;
	endtask

	task automatic push_tick(logic dis, logic ioq, logic rd, logic wr, logic [7:0] addr,
			logic [7:0] wd, logic [7:0] ab, logic [7:0] bm);
		queue_tick({dis, ioq, rd, wr, addr, wd, ab, bm});
	endtask

	// hold the serial line at a level, forcing a control write where it must change
	task automatic push_line(bit want);
		if (want != gen_line || $urandom_range(0, 7) == 0)
			queue_tick(line_tick(want));
		else
			queue_tick(rand_tick(want));
	endtask

	// arm tick, start window, eight data windows (LSB first), then stop level
	task automatic push_frame(logic [7:0] data, int unsigned bt);
		for (int unsigned p = 0; p <= FRAME_BITS * bt + 1; p++) begin
			if (p <= 2 * bt)
				push_line(1'b0);
			else if (p > FRAME_BITS * bt)
				push_line(1'b1);
			else
				push_line(data[(p - 1) / bt - 2]);
		end
	endtask

	task automatic push_quiet(int unsigned n);
		repeat (n) push_line(1'b1);
	endtask

	task automatic run_frames(int unsigned bt, int unsigned n);
		int unsigned base;
		int unsigned skew;
		base = gen_cnt;
		push_quiet(FRAME_BITS * bt + 2);
		while (gen_cnt < base + n) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(5, 20)) push_line($urandom_range(0, 1));
				push_quiet(FRAME_BITS * bt + 2);
			end else if ($urandom_range(0, 7) == 0) begin
				skew = ($urandom_range(0, 1) && bt > 1) ? bt - 1 : bt + 1;
				push_frame($urandom_range(0, 255), skew);
				push_quiet(FRAME_BITS * bt + 2);
			end else begin
				push_frame($urandom_range(0, 255), bt);
				push_quiet($urandom_range(0, 3));
			end
		end
	endtask

	task automatic write_bit_time(logic [15:0] v);
		@(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		bit_time = v;
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (bus_ticks.size() != 0 || in_valid || pending_results.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive
		bus_result_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				decode_and_receive(cur, r);
				pending_results.push_back(r);
				acc_cnt <= acc_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (bus_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur = bus_ticks.pop_front();
					{chip_disabled, ioreq_n, rd_n, wr_n, address_low, write_data,
						port_ab_pins, port_bm_pins} <= cur;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off, started once at a chosen beat count
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!stall_done && acc_cnt == stall_at) begin
			stall_left <= 150;
			stall_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// monitor
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		bus_result_t want;
		bus_result_t got;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {read_data, read_valid, rx_byte, rx_valid};
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat %h", $time, got);
				end else begin
					want = pending_results.pop_front();
					ticks_checked++;
					if (got.read_valid) port_reads++;
					if (got.rx_valid) rx_bytes++;
					if (got.read_data != want.read_data) begin
						errors++;
						$display("%0t: read_data expected %h, got %h", $time,
							want.read_data, got.read_data);
					end
					if (got.read_valid != want.read_valid) begin
						errors++;
						$display("%0t: read_valid expected %b, got %b", $time,
							want.read_valid, got.read_valid);
					end
					if (got.rx_byte != want.rx_byte) begin
						errors++;
						$display("%0t: rx_byte expected %h, got %h", $time,
							want.rx_byte, got.rx_byte);
					end
					if (got.rx_valid != want.rx_valid) begin
						errors++;
						$display("%0t: rx_valid expected %b, got %b", $time,
							want.rx_valid, got.rx_valid);
					end
				end
			end
			out_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= RUN_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
			pending_results.size());
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 11;
		rcv_idle_pct  = 60;

		// decode corners at the reset bit time
		push_tick(0, 0, 0, 1, 8'hC0, 8'h5A, 8'h00, 8'hFF);
		push_tick(0, 0, 0, 1, 8'hFE, 8'hA5, 8'hFF, 8'h00);
		push_tick(0, 0, 0, 1, 8'hC1, 8'h00, 8'hFF, 8'h00);
		push_tick(0, 0, 0, 1, 8'hFF, 8'hFF, 8'h00, 8'hFF);
		push_tick(0, 0, 0, 1, 8'hBF, 8'h12, 8'h34, 8'h56);
		push_tick(0, 0, 0, 1, 8'h00, 8'h12, 8'h34, 8'h56);
		push_tick(0, 0, 1, 0, 8'h01, 8'hFF, 8'h11, 8'h22);
		push_tick(0, 0, 1, 0, 8'h3F, 8'h00, 8'h33, 8'h44);   // line low arms receiver
		push_tick(0, 0, 1, 0, 8'h3E, 8'hFF, 8'h55, 8'h66);
		push_tick(0, 0, 1, 0, 8'h41, 8'hFF, 8'h77, 8'h88);
		push_tick(0, 0, 0, 0, 8'h21, 8'h80, 8'h99, 8'hAA);   // write wins over read
		push_tick(0, 0, 0, 0, 8'hC2, 8'h00, 8'hBB, 8'hCC);   // write misses, read decodes
		push_tick(0, 0, 0, 0, 8'hC3, 8'h00, 8'hDD, 8'hEE);
		push_tick(1, 0, 0, 1, 8'hC0, 8'h00, 8'hFF, 8'hFF);
		push_tick(0, 1, 0, 1, 8'hC1, 8'h00, 8'hFF, 8'hFF);
		push_tick(1, 0, 1, 0, 8'h01, 8'h00, 8'h00, 8'h00);
		push_tick(0, 0, 1, 1, 8'hC0, 8'h00, 8'hFF, 8'hFF);
		push_tick(0, 0, 1, 0, 8'h01, 8'hFF, 8'h00, 8'h00);
		drain();

		// zero bit time: an armed receiver drops out at once
		write_bit_time(16'd0);
		queue_tick(line_tick(1'b0));
		repeat (12) push_line($urandom_range(0, 1));
		drain();

		// longest bit time: arm and leave the receiver mid-frame
		write_bit_time(16'hFFFF);
		queue_tick(line_tick(1'b0));
		repeat (10) push_line(1'b0);
		drain();

		// shorter bit time while armed: windows move, the start window gets skipped
		write_bit_time(16'd3);
		run_frames(3, RAND_ITEMS);
		drain();

		send_idle_pct = 60;
		rcv_idle_pct  = 11;
		write_bit_time(16'd1);
		run_frames(1, RAND_ITEMS);
		drain();

		send_idle_pct = 0;
		rcv_idle_pct  = 0;
		write_bit_time(16'd2);
		stall_at = acc_cnt + 80;
		run_frames(2, RAND_ITEMS);
		drain();

		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("%0d bus ticks checked: %0d port reads, %0d serial bytes received",
			ticks_checked, port_reads, rx_bytes);
		$display("bit times 100, 0, 65535, 3, 1, 2; one long output hold-off");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
sv/iopd_pkg.sv
sv/iopd_decode.sv
sv/iopd_rx.sv
sv/io_port_decode_with_uart_rx_unit.sv
tb/tb.sv
